// File: hw/rtl/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer_assert
// Assertion macros used by the console writer datapath.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// check that cond holds on every clock edge out of reset
`define TCW_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// check that trig implies cond in the same cycle
`define TCW_ASSERT_IMPLY(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// check that trig implies cond in the next cycle
`define TCW_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and fixed constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int REQ_W   = 1;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int COL_W   = 7;
    localparam int LINE_W  = 5;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    localparam logic [REQ_W-1:0]  REQ_PUT      = 1'b0;
    localparam logic [REQ_W-1:0]  REQ_READ     = 1'b1;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_COPY,
        OP_DRAIN,
        OP_FILL
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic ptr_last;
        logic scroll_need;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hw/rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Handshake channels of the text console writer: request, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_in_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::REQ_W-1:0]    req_type;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::IDX_W-1:0]    cell_index;

    modport source (output valid, req_type, char_code, cell_index, input ready);
    modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_out_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::COL_W-1:0]    cursor_col;
    logic [tcw_pkg::LINE_W-1:0]   cursor_line;
    logic                         did_scroll;
    logic [tcw_pkg::CELL_W-1:0]   cell_value;

    modport source (output valid, cursor_col, cursor_line, did_scroll, cell_value,
                    input ready);
    modport sink   (input valid, cursor_col, cursor_line, did_scroll, cell_value,
                    output ready);
endinterface

interface tcw_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::ATTR_W-1:0]   text_attribute;

    modport source (output valid, text_attribute, input ready);
    modport sink   (input valid, text_attribute, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, cell store, scroll pointers, attribute and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_assert.svh"

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tcw_pkg::t_dp_cmd             i_cmd,
    output tcw_pkg::t_dp_status               o_status,
    input  wire logic [tcw_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]    i_cell_index,
    input  wire logic                         i_cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]   i_cfg_attr,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [tcw_pkg::COL_W-1:0]         o_cursor_col,
    output logic [tcw_pkg::LINE_W-1:0]        o_cursor_line,
    output logic                              o_did_scroll,
    output logic [tcw_pkg::CELL_W-1:0]        o_cell_value
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CPOS_W     = $clog2(COLUMNS + 1);
    localparam int LPOS_W     = $clog2(ROWS + 1);

    logic [tcw_pkg::CELL_W-1:0] r_mem [CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    logic [CPOS_W-1:0]          r_col;
    logic [LPOS_W-1:0]          r_line;
    logic [ADDR_W-1:0]          r_ptr;
    logic [ADDR_W-1:0]          r_wr_addr;
    logic                       r_wr_pend;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic                       r_res_scroll;
    logic                       r_rd_hit;

    logic                       r_out_valid;
    logic [tcw_pkg::COL_W-1:0]  r_out_col;
    logic [tcw_pkg::LINE_W-1:0] r_out_line;
    logic                       r_out_scroll;
    logic [tcw_pkg::CELL_W-1:0] r_out_value;

    logic                       is_put;
    logic                       is_nl;
    logic                       in_range;
    logic                       scroll_need;
    logic [CPOS_W-1:0]          col_inc;
    logic [CPOS_W-1:0]          n_col;
    logic [LPOS_W-1:0]          n_line;
    logic [ADDR_W-1:0]          put_addr;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;

    assign is_put   = (i_req_type == tcw_pkg::REQ_PUT);
    assign is_nl    = (i_char_code == tcw_pkg::NEWLINE_CODE);
    assign in_range = (32'(i_cell_index) < CELL_COUNT);
    assign col_inc  = r_col + CPOS_W'(1);
    assign put_addr = ADDR_W'(32'(r_line) * COLUMNS + 32'(r_col));

    // cursor after a put; wrap at the right edge, clamp to the bottom row on scroll
    always_comb begin
        n_col  = col_inc;
        n_line = r_line;
        if (is_nl || (col_inc == CPOS_W'(COLUMNS))) begin
            n_col  = '0;
            n_line = r_line + LPOS_W'(1);
        end
        scroll_need = (n_line == LPOS_W'(ROWS));
        if (scroll_need) begin
            n_line = LPOS_W'(ROWS - 1);
        end
    end

    // single write port: pending copy word first, then the op's own write
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = tcw_pkg::RESET_CELL;
        if (r_wr_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_wr_addr;
            mem_wdata = r_rd_data;
        end else begin
            case (i_cmd.op)
                tcw_pkg::OP_CLEAR: begin
                    mem_we = 1'b1;
                end
                tcw_pkg::OP_FILL: begin
                    mem_we    = 1'b1;
                    mem_wdata = {r_attr, tcw_pkg::SPACE_CODE};
                end
                tcw_pkg::OP_ACCEPT: begin
                    mem_we    = is_put && !is_nl;
                    mem_waddr = put_addr;
                    mem_wdata = {r_attr, i_char_code};
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_ptr;
        if (i_cmd.op == tcw_pkg::OP_COPY) begin
            mem_re = 1'b1;
        end else if (i_cmd.op == tcw_pkg::OP_ACCEPT) begin
            mem_re    = !is_put && in_range;
            mem_raddr = ADDR_W'(i_cell_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_line      <= '0;
            r_ptr       <= '0;
            r_wr_pend   <= 1'b0;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= (i_cmd.op == tcw_pkg::OP_COPY);
            if (i_cfg_we) begin
                r_attr <= i_cfg_attr;
            end
            case (i_cmd.op)
                tcw_pkg::OP_CLEAR, tcw_pkg::OP_COPY, tcw_pkg::OP_FILL: begin
                    r_ptr <= r_ptr + ADDR_W'(1);
                end
                tcw_pkg::OP_DRAIN: begin
                    r_ptr <= ADDR_W'(CELL_COUNT - COLUMNS);
                end
                tcw_pkg::OP_ACCEPT: begin
                    if (is_put) begin
                        r_col  <= n_col;
                        r_line <= n_line;
                        // first source word of the scroll is the second row
                        r_ptr  <= ADDR_W'(COLUMNS);
                    end
                end
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_ptr - ADDR_W'(COLUMNS);
        if (i_cmd.op == tcw_pkg::OP_ACCEPT) begin
            r_res_scroll <= is_put && scroll_need;
            r_rd_hit     <= !is_put && in_range;
        end
        if (i_cmd.load_out) begin
            r_out_col    <= tcw_pkg::COL_W'(r_col);
            r_out_line   <= tcw_pkg::LINE_W'(r_line);
            r_out_scroll <= r_res_scroll;
            r_out_value  <= r_rd_hit ? r_rd_data : '0;
        end
    end

    assign o_status.ptr_last    = (r_ptr == ADDR_W'(CELL_COUNT - 1));
    assign o_status.scroll_need = is_put && scroll_need;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_cursor_col  = r_out_col;
    assign o_cursor_line = r_out_line;
    assign o_did_scroll  = r_out_scroll;
    assign o_cell_value  = r_out_value;

    `TCW_ASSERT_ALWAYS(a_col_range, i_clk, i_rst_n, 32'(r_col) < COLUMNS, "cursor column out of range")
    `TCW_ASSERT_ALWAYS(a_line_range, i_clk, i_rst_n, 32'(r_line) < ROWS, "cursor row out of range")
    `TCW_ASSERT_IMPLY(a_copy_addr, i_clk, i_rst_n, r_wr_pend, 32'(r_wr_addr) < CELL_COUNT - COLUMNS, "copy write past last row start")
    `TCW_ASSERT_IMPLY(a_scroll_row, i_clk, i_rst_n, r_out_valid && r_out_scroll, r_out_line == tcw_pkg::LINE_W'(ROWS - 1), "scroll result not on bottom row")

endmodule

`default_nettype wire

// File: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: clearing pass, request accept, scroll copy and fill, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire tcw_pkg::t_dp_status   i_status,
    output tcw_pkg::t_dp_cmd           o_cmd
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.op       = tcw_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                o_cmd.op = tcw_pkg::OP_CLEAR;
                if (i_status.ptr_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = tcw_pkg::OP_ACCEPT;
                    n_state  = i_status.scroll_need ? tcw_pkg::ST_COPY : tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_COPY: begin
                o_cmd.op = tcw_pkg::OP_COPY;
                if (i_status.ptr_last) begin
                    n_state = tcw_pkg::ST_DRAIN;
                end
            end
            tcw_pkg::ST_DRAIN: begin
                // last copy word writes here
                o_cmd.op = tcw_pkg::OP_DRAIN;
                n_state  = tcw_pkg::ST_FILL;
            end
            tcw_pkg::ST_FILL: begin
                o_cmd.op = tcw_pkg::OP_FILL;
                if (i_status.ptr_last) begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                // hold until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/text_console_writer.sv
// Text console writer, COLUMNS x ROWS cells in one single-port-write memory.
// Put without scroll, or read: the result is loaded once the output register is free; no new request before that.
// Put that scrolls: states COPY, DRAIN and FILL move the rows up and blank the bottom row, one cell copy per cycle.
// Reset: a clearing pass writes all COLUMNS*ROWS cells (2000 at 80x25), input not ready.
// Configuration writes are taken at any time, also during the clearing pass.
// ----------------------------------------------------------------------------
// text_console_writer
// Top level: request, result and attribute channels around control and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out,
    tcw_cfg_if.sink    i_cfg
);

    tcw_pkg::t_dp_cmd    cmd;
    tcw_pkg::t_dp_status status;

    assign i_cfg.ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (i_in.req_type),
        .i_char_code   (i_in.char_code),
        .i_cell_index  (i_in.cell_index),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_attr    (i_cfg.text_attribute),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_cursor_col  (o_out.cursor_col),
        .o_cursor_line (o_out.cursor_line),
        .o_did_scroll  (o_out.did_scroll),
        .o_cell_value  (o_out.cell_value)
    );

endmodule

`default_nettype wire

// File: tb/tb_text_console_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the 80x25 text console writer. A directed table
// covers reads at the ends of the store, out-of-range reads, glyph extremes
// and newlines. Random line, wrap, read and noise runs then push the cursor
// through right-edge wraps and bottom-row scrolls under four attribute
// settings. A shadow copy of the screen predicts each result word that the table does not give.
// ----------------------------------------------------------------------------

module tb_text_console_writer;

    import tcw_pkg::*;

    localparam int SCREEN_COLS    = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLS * SCREEN_ROWS;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DIRECTED_COUNT = 25;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [LINE_W-1:0] cursor_line;
        logic              did_scroll;
        logic [CELL_W-1:0] cell_value;
    } t_console_reply;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        t_console_reply    want;
    } t_stim_row;

    // typed rows carry their result; the rest take the shadow screen's
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{REQ_READ, 8'h00,        11'd0,    1'b1, '{7'd0, 5'd0, 1'b0, 16'h0F20}},
        '{REQ_READ, 8'hFF,        11'd1999, 1'b1, '{7'd0, 5'd0, 1'b0, 16'h0F20}},
        '{REQ_READ, 8'h00,        11'd2000, 1'b1, '{7'd0, 5'd0, 1'b0, 16'h0000}},
        '{REQ_READ, 8'h00,        11'd2047, 1'b1, '{7'd0, 5'd0, 1'b0, 16'h0000}},
        '{REQ_PUT,  8'h41,        11'd0,    1'b1, '{7'd1, 5'd0, 1'b0, 16'h0000}},
        '{REQ_PUT,  8'h00,        11'd2047, 1'b1, '{7'd2, 5'd0, 1'b0, 16'h0000}},
        '{REQ_PUT,  8'hFF,        11'd0,    1'b1, '{7'd3, 5'd0, 1'b0, 16'h0000}},
        '{REQ_READ, 8'h00,        11'd0,    1'b1, '{7'd3, 5'd0, 1'b0, 16'h0F41}},
        '{REQ_READ, 8'h00,        11'd1,    1'b1, '{7'd3, 5'd0, 1'b0, 16'h0F00}},
        '{REQ_READ, 8'h00,        11'd2,    1'b1, '{7'd3, 5'd0, 1'b0, 16'h0FFF}},
        '{REQ_READ, 8'h00,        11'd3,    1'b1, '{7'd3, 5'd0, 1'b0, 16'h0F20}},
        '{REQ_PUT,  NEWLINE_CODE, 11'd0,    1'b1, '{7'd0, 5'd1, 1'b0, 16'h0000}},
        '{REQ_PUT,  8'h7E,        11'd0,    1'b1, '{7'd1, 5'd1, 1'b0, 16'h0000}},
        '{REQ_READ, 8'h00,        11'd80,   1'b1, '{7'd1, 5'd1, 1'b0, 16'h0F7E}},
        '{REQ_PUT,  NEWLINE_CODE, 11'd0,    1'b1, '{7'd0, 5'd2, 1'b0, 16'h0000}},
        '{REQ_PUT,  NEWLINE_CODE, 11'd2047, 1'b1, '{7'd0, 5'd3, 1'b0, 16'h0000}},
        '{REQ_PUT,  8'h80,        11'd0,    1'b1, '{7'd1, 5'd3, 1'b0, 16'h0000}},
        '{REQ_READ, 8'h00,        11'd240,  1'b1, '{7'd1, 5'd3, 1'b0, 16'h0F80}},
        '{REQ_PUT,  SPACE_CODE,   11'd555,  1'b0, '0},
        '{REQ_PUT,  8'h55,        11'd0,    1'b0, '0},
        '{REQ_PUT,  8'hAA,        11'h2AA,  1'b0, '0},
        '{REQ_READ, 8'h00,        11'd241,  1'b0, '0},
        '{REQ_READ, 8'hFF,        11'd242,  1'b0, '0},
        '{REQ_READ, 8'h00,        11'd1920, 1'b0, '0},
        '{REQ_READ, 8'h00,        11'd1023, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();
    tcw_cfg_if cfg_ch ();

    text_console_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow screen, cursor and attribute
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int                shadow_col;
    int                shadow_line;
    logic [ATTR_W-1:0] shadow_attr;

    t_console_reply expected_replies [$];
    int             mismatch_count = 0;
    int             items_sent     = 0;
    int             in_gap_pct     = 20;
    int             out_stall_pct  = 4;

    task automatic console_step(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx, output t_console_reply r);
        int pos;
        r = '0;
        if (req == REQ_READ) begin
            if (idx < CELL_COUNT) r.cell_value = shadow_cells[idx];
        end else begin
            if (ch == NEWLINE_CODE) begin
                shadow_col = 0;
                shadow_line++;
            end else begin
                pos = shadow_line * SCREEN_COLS + shadow_col;
                shadow_cells[pos] = {shadow_attr, ch};
                shadow_col++;
            end
            if (shadow_col >= SCREEN_COLS) begin
                shadow_col = 0;
                shadow_line++;
            end
            // scroll: move every row up one, blank the bottom row
            if (shadow_line >= SCREEN_ROWS) begin
                shadow_line = SCREEN_ROWS - 1;
                for (pos = 0; pos < CELL_COUNT - SCREEN_COLS; pos++)
                    shadow_cells[pos] = shadow_cells[pos + SCREEN_COLS];
                for (pos = CELL_COUNT - SCREEN_COLS; pos < CELL_COUNT; pos++)
                    shadow_cells[pos] = {shadow_attr, SPACE_CODE};
                r.did_scroll = 1'b1;
            end
        end
        r.cursor_col  = COL_W'(shadow_col);
        r.cursor_line = LINE_W'(shadow_line);
    endtask

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx, input logic has_want,
                             input t_console_reply want);
        t_console_reply predicted;
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= req;
        in_ch.char_code  <= ch;
        in_ch.cell_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        console_step(req, ch, idx, predicted);
        expected_replies.push_back(has_want ? want : predicted);
        items_sent++;
        if ($urandom_range(0, 99) < in_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // cells near the cursor, the last cell, any cell, or past the end
    function automatic logic [IDX_W-1:0] pick_read_index();
        int roll;
        int row;
        roll = $urandom_range(0, 99);
        row  = shadow_line - $urandom_range(0, (shadow_line < 2) ? shadow_line : 2);
        if (roll < 10) return IDX_W'(CELL_COUNT + $urandom_range(0, 2047 - CELL_COUNT));
        if (roll < 50) return IDX_W'(row * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
        if (roll < 53) return IDX_W'(CELL_COUNT - 1);
        return IDX_W'($urandom_range(0, CELL_COUNT - 1));
    endfunction

    task automatic drain_results(input int extra_cycles);
        in_ch.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] attr);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.text_attribute <= attr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_attr = attr;
    endtask

    task automatic run_phase(input int stop_at, input logic idle_on);
        int kind;
        int n;
        int k;
        while (items_sent < stop_at) begin
            if (!idle_on) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        in_gap_pct    = 0;
                        out_stall_pct = 0;
                    end
                    1: begin
                        in_gap_pct    = 20;
                        out_stall_pct = 4;
                    end
                    default: begin
                        in_gap_pct    = 50;
                        out_stall_pct = 12;
                    end
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // short line ended by a newline
                n = $urandom_range(0, 20);
                for (k = 0; k < n; k++)
                    send_item(REQ_PUT, CHAR_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2047)), 1'b0, '0);
                send_item(REQ_PUT, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)), 1'b0, '0);
            end else if (kind < 55) begin
                // long line of SCREEN_COLS - 4 to SCREEN_COLS + 4 puts, up to or across the right edge
                n = $urandom_range(SCREEN_COLS - 4, SCREEN_COLS + 4);
                for (k = 0; k < n; k++)
                    send_item(REQ_PUT, CHAR_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2047)), 1'b0, '0);
                if ($urandom_range(0, 1))
                    send_item(REQ_PUT, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)),
                              1'b0, '0);
            end else if (kind < 90) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    send_item(REQ_READ, CHAR_W'($urandom_range(0, 255)),
                              pick_read_index(), 1'b0, '0);
            end else begin
                send_item(REQ_W'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                          IDX_W'($urandom_range(0, 2047)), 1'b0, '0);
            end
        end
    endtask

    initial begin : stimulus
        int i;
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.req_type        = REQ_PUT;
        in_ch.char_code       = '0;
        in_ch.cell_index      = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.text_attribute = '0;
        for (i = 0; i < CELL_COUNT; i++) shadow_cells[i] = RESET_CELL;
        shadow_col  = 0;
        shadow_line = 0;
        shadow_attr = ATTR_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_COUNT; i++)
            send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].idx,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // hold off writes past any scroll still in flight
        drain_results(CELL_COUNT + 16);
        write_attribute(8'h00);
        run_phase(500, 1'b1);
        drain_results(CELL_COUNT + 16);
        write_attribute(8'hFF);
        run_phase(1000, 1'b1);
        drain_results(CELL_COUNT + 16);
        write_attribute(ATTR_W'($urandom_range(0, 255)));
        run_phase(1500, 1'b1);
        drain_results(CELL_COUNT + 16);
        write_attribute(ATTR_W'($urandom_range(0, 255)));
        run_phase(1950, 1'b0);

        drain_results(16);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : result_side
        t_console_reply got;
        t_console_reply want;
        int             stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.cursor_col  = out_ch.cursor_col;
                got.cursor_line = out_ch.cursor_line;
                got.did_scroll  = out_ch.did_scroll;
                got.cell_value  = out_ch.cell_value;
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected word col %0d line %0d scroll %0b cell %h",
                                 $realtime, got.cursor_col, got.cursor_line,
                                 got.did_scroll, got.cell_value);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.cursor_col !== want.cursor_col ||
                        got.cursor_line !== want.cursor_line ||
                        got.did_scroll !== want.did_scroll ||
                        got.cell_value !== want.cell_value) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: expected %0d %0d %0b %h, got %0d %0d %0b %h",
                                     $realtime, want.cursor_col, want.cursor_line,
                                     want.did_scroll, want.cell_value, got.cursor_col,
                                     got.cursor_line, got.did_scroll, got.cell_value);
                    end
                end
            end
            // stall the result side in bursts
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < out_stall_pct) begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_datapath.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
tb/tb_text_console_writer.sv
